// ===== sv/bmpse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bmpse_pkg
// Types, constants and helper functions shared by the BMP stream encoder.
// ============================================================================
package bmpse_pkg;

    // Byte position inside the byte sequence of one pixel:
    // header bytes first, then pixel bytes, then row padding.
    typedef logic [5:0] t_idx;

    localparam t_idx IDX_PIXEL = 6'd54;   // first pixel byte, right after the header
    localparam t_idx IDX_FIELDS = 6'd2;   // first 32-bit header field, after "BM"

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FORMAT = 2'd2;

    // Fixed header values
    localparam logic [7:0]  SIG_B     = 8'h42;
    localparam logic [7:0]  SIG_M     = 8'h4D;
    localparam logic [31:0] HDR_SIZE  = 32'd54;
    localparam logic [31:0] INFO_SIZE = 32'd40;
    localparam logic [31:0] PPM_72DPI = 32'h0000_0B13;

    // Word numbers of the 32-bit header fields (counted from byte 2)
    localparam logic [3:0] W_TOTAL  = 4'd0;
    localparam logic [3:0] W_OFFSET = 4'd2;
    localparam logic [3:0] W_INFO   = 4'd3;
    localparam logic [3:0] W_WIDTH  = 4'd4;
    localparam logic [3:0] W_HEIGHT = 4'd5;
    localparam logic [3:0] W_PLANES = 4'd6;
    localparam logic [3:0] W_DATA   = 4'd8;
    localparam logic [3:0] W_XPPM   = 4'd9;
    localparam logic [3:0] W_YPPM   = 4'd10;

    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_BGRA32 = 2'd2
    } t_fmt;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        t_fmt       fmt;
    } t_pixel;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] data;
        logic [31:0] width;
        logic [31:0] height;
        logic [7:0]  bpp;
    } t_hdr;

    // Map the raw format code; the unused code falls back to 5-5-5
    function automatic t_fmt norm_fmt(logic [1:0] code);
        t_fmt f;
        case (code)
            FMT_BGR24:  f = FMT_BGR24;
            FMT_BGRA32: f = FMT_BGRA32;
            default:    f = FMT_RGB555;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] bytes_per_pixel(t_fmt f);
        logic [2:0] n;
        case (f)
            FMT_BGR24:  n = 3'd3;
            FMT_BGRA32: n = 3'd4;
            default:    n = 3'd2;
        endcase
        return n;
    endfunction

    // One byte of the 54-byte file header
    function automatic logic [7:0] hdr_byte(t_idx idx, t_hdr hdr);
        t_idx        k;
        logic [31:0] word;
        logic [7:0]  b;
        k = idx - IDX_FIELDS;
        case (k[5:2])
            W_TOTAL:  word = hdr.total;
            W_OFFSET: word = HDR_SIZE;
            W_INFO:   word = INFO_SIZE;
            W_WIDTH:  word = hdr.width;
            W_HEIGHT: word = hdr.height;
            W_PLANES: word = {8'd0, hdr.bpp, 16'd1};
            W_DATA:   word = hdr.data;
            W_XPPM:   word = PPM_72DPI;
            W_YPPM:   word = PPM_72DPI;
            default:  word = 32'd0;
        endcase
        case (k[1:0])
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        if (idx == 6'd0) begin
            b = SIG_B;
        end else if (idx == 6'd1) begin
            b = SIG_M;
        end
        return b;
    endfunction

endpackage

// ===== sv/bmpse_byte_mux.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bmpse_byte_mux
// Selects the file byte at a sequence position: header byte, encoded pixel
// byte or zero padding.
// ============================================================================
module bmpse_byte_mux (
    input  bmpse_pkg::t_idx   i_idx,
    input  bmpse_pkg::t_pixel i_pix,
    input  bmpse_pkg::t_hdr   i_hdr,
    output logic [7:0]        o_byte
);

    bmpse_pkg::t_idx off;
    logic [15:0]     rgb555;
    logic [7:0]      pix_byte;
    logic [2:0]      bpb;

    assign off    = i_idx - bmpse_pkg::IDX_PIXEL;
    assign bpb    = bmpse_pkg::bytes_per_pixel(i_pix.fmt);
    assign rgb555 = {1'b0, i_pix.red[7:3], i_pix.green[7:3], i_pix.blue[7:3]};

    // Encode the pixel byte at this offset
    always_comb begin
        if (i_pix.fmt == bmpse_pkg::FMT_RGB555) begin
            pix_byte = off[0] ? rgb555[15:8] : rgb555[7:0];
        end else begin
            case (off[1:0])
                2'd0:    pix_byte = i_pix.blue;
                2'd1:    pix_byte = i_pix.green;
                2'd2:    pix_byte = i_pix.red;
                default: pix_byte = i_pix.alpha;
            endcase
        end
    end

    // Pick header, pixel or padding
    always_comb begin
        if (i_idx < bmpse_pkg::IDX_PIXEL) begin
            o_byte = bmpse_pkg::hdr_byte(i_idx, i_hdr);
        end else if (off < 6'(bpb)) begin
            o_byte = pix_byte;
        end else begin
            o_byte = 8'd0;
        end
    end

endmodule

// ===== sv/bmp_stream_encoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bmp_stream_encoder
// Turns a row-major stream of RGBA pixels into the byte stream of an
// uncompressed BMP file: header before the first pixel, 16/24/32-bit pixel
// encoding, zero padding of each row to four bytes.
//
// Channel  Direction  Handshake                Payload
// -------  ---------  -----------------------  ---------------------------------
// in       sink       i_in_valid / o_in_ready  i_red, i_green, i_blue, i_alpha
// out      source     o_out_valid / i_out_ready o_data_byte, o_run_end, o_file_end
// cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One file byte leaves per cycle through the output register, and an output
// stall holds it there. A pixel is 2 to 4 bytes plus 0 to 3 padding bytes
// at a row end, and the 54 header bytes precede the first pixel of a file;
// the next pixel is taken in the cycle its predecessor's last byte is
// loaded. The header size product is pipelined, so pixel input is held off
// after reset and each configuration transfer. Reset is synchronous.
// ============================================================================
module bmp_stream_encoder #(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_run_end,
    output logic        o_file_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Configuration registers
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [1:0]  r_format;
    logic [1:0]  r_settle;

    // Header size pipeline
    logic [17:0] r_row_bytes;
    logic [31:0] r_data;
    logic [31:0] r_total;

    // Position counters
    logic [DIM_BITS-1:0] r_col;
    logic [DIM_BITS-1:0] r_row;
    logic                r_hdr_done;

    // Item register
    logic              r_busy;
    bmpse_pkg::t_idx   r_idx;
    bmpse_pkg::t_idx   r_last_idx;
    logic              r_file_last;
    bmpse_pkg::t_pixel r_pix;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_file_end;

    logic [31:0]         w_raw32;
    logic [31:0]         h_raw32;
    logic [DIM_BITS-1:0] w_dim;
    logic [DIM_BITS-1:0] h_dim;
    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;
    logic [31:0]         w_eff32;
    logic [31:0]         h_eff32;
    bmpse_pkg::t_fmt     fmt_cfg;
    logic [2:0]          bpb_cfg;
    logic [17:0]         w18;
    logic [17:0]         n_row_bytes;
    logic [33:0]         data_prod;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;
    logic                row_last;
    logic                file_last;
    logic [1:0]          pad;
    bmpse_pkg::t_idx     n_last_idx;
    logic                slot_free;
    logic                step;
    logic                at_last;
    logic                in_xfer;
    logic                cfg_xfer;
    bmpse_pkg::t_hdr     hdr;
    logic [7:0]          mux_byte;

    // Effective dimensions: masked to DIM_BITS, zero reads as one
    assign w_raw32 = 32'(r_width);
    assign h_raw32 = 32'(r_height);
    assign w_dim   = w_raw32[DIM_BITS-1:0];
    assign h_dim   = h_raw32[DIM_BITS-1:0];
    assign w_eff   = (w_dim == '0) ? DIM_BITS'(1) : w_dim;
    assign h_eff   = (h_dim == '0) ? DIM_BITS'(1) : h_dim;
    assign w_eff32 = 32'(w_eff);
    assign h_eff32 = 32'(h_eff);
    assign fmt_cfg = bmpse_pkg::norm_fmt(r_format);
    assign bpb_cfg = bmpse_pkg::bytes_per_pixel(fmt_cfg);

    // Row size in bytes, rounded up to four
    assign w18 = w_eff32[17:0];
    always_comb begin
        case (fmt_cfg)
            bmpse_pkg::FMT_BGR24:  n_row_bytes = w18 + {w18[16:0], 1'b0};
            bmpse_pkg::FMT_BGRA32: n_row_bytes = {w18[15:0], 2'b00};
            default:               n_row_bytes = {w18[16:0], 1'b0};
        endcase
        n_row_bytes = (n_row_bytes + 18'd3) & ~18'd3;
    end
    assign data_prod = r_row_bytes * h_eff32[15:0];

    // Row and file end detection
    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign row_inc   = {1'b0, r_row} + 1'b1;
    assign row_last  = col_inc >= {1'b0, w_eff};
    assign file_last = row_last && (row_inc >= {1'b0, h_eff});

    // Padding after the row's last pixel
    always_comb begin
        case (fmt_cfg)
            bmpse_pkg::FMT_BGR24:  pad = w_eff32[1:0];
            bmpse_pkg::FMT_BGRA32: pad = 2'd0;
            default:               pad = {w_eff32[0], 1'b0};
        endcase
        if (!row_last) begin
            pad = 2'd0;
        end
    end
    assign n_last_idx = bmpse_pkg::IDX_PIXEL - 6'd1 + 6'(bpb_cfg) + 6'(pad);

    // Handshakes
    assign slot_free   = !r_out_valid || i_out_ready;
    assign step        = r_busy && slot_free;
    assign at_last     = (r_idx == r_last_idx);
    assign o_in_ready  = (!r_busy || (step && at_last)) && !i_cfg_valid
                         && (r_settle == 2'd0);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Header field values
    assign hdr.total  = r_total;
    assign hdr.data   = r_data;
    assign hdr.width  = w_eff32;
    assign hdr.height = h_eff32;
    assign hdr.bpp    = {2'b00, bpb_cfg, 3'b000};

    bmpse_byte_mux u_mux (
        .i_idx  (r_idx),
        .i_pix  (r_pix),
        .i_hdr  (hdr),
        .o_byte (mux_byte)
    );

    // Configuration writes and input hold-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_format <= bmpse_pkg::FMT_BGR24;
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (cfg_xfer) begin
                r_settle <= SETTLE_CYCLES;
                case (i_cfg_index)
                    bmpse_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    bmpse_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    bmpse_pkg::CFG_FORMAT: r_format <= i_cfg_data[1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // Advance the header size pipeline
    always_ff @(posedge i_clk) begin
        r_row_bytes <= n_row_bytes;
        r_data      <= data_prod[31:0];
        r_total     <= r_data + bmpse_pkg::HDR_SIZE;
    end

    // Column, row and header state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_hdr_done <= 1'b0;
        end else if (in_xfer) begin
            if (file_last) begin
                r_col      <= '0;
                r_row      <= '0;
                r_hdr_done <= 1'b0;
            end else if (row_last) begin
                r_col      <= '0;
                r_row      <= row_inc[DIM_BITS-1:0];
                r_hdr_done <= 1'b1;
            end else begin
                r_col      <= col_inc[DIM_BITS-1:0];
                r_hdr_done <= 1'b1;
            end
        end
    end

    // Item register control: load on transfer, step one byte per free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
            r_idx  <= r_hdr_done ? bmpse_pkg::IDX_PIXEL : 6'd0;
        end else if (step) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix.red   <= i_red;
            r_pix.green <= i_green;
            r_pix.blue  <= i_blue;
            r_pix.alpha <= i_alpha;
            r_pix.fmt   <= fmt_cfg;
            r_last_idx  <= n_last_idx;
            r_file_last <= file_last;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte     <= mux_byte;
            r_run_end  <= at_last;
            r_file_end <= at_last && r_file_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_byte;
    assign o_run_end   = r_run_end;
    assign o_file_end  = r_file_end;

endmodule

// ===== sv/bmpse_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bmpse_checker
// Port-level checks on the BMP stream encoder, bound to the top level.
// ============================================================================
module bmpse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_red,
    input logic [7:0]  i_green,
    input logic [7:0]  i_blue,
    input logic [7:0]  i_alpha,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_data_byte,
    input logic        o_run_end,
    input logic        o_file_end,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The file's last byte also closes its pixel
    a_file_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_file_end |-> o_run_end)
        else $error("file end without run end");

    // Pixel input is held off right after a configuration transfer
    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("pixel accepted right after configuration transfer");

    // A stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_run_end) && $stable(o_file_end))
        else $error("stalled output byte changed");

endmodule

bind bmp_stream_encoder bmpse_checker u_bmpse_checker (.*);
